// ----- sv/brl_pkg.sv -----
// brl_pkg: shared constants and types of the bresenham line rasterizer
// no dependencies; imported by every rtl module and the checker

package brl_pkg;

    // command codes on the input channel
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // pixel color width
    localparam int COLOR_BITS = 16;

    // depth of the queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;

    // queue status seen by the front and the back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ----- sv/bresenham_line_rasterizer.sv -----
// bresenham_line_rasterizer: one item a cycle in while o_stall is low, one pixel
// a cycle out while i_stall is low. a step transfer is written into the queue
// and popped from it into the output register; the queue holds up to four.
// reset (synchronous, active low) drops any line, empties the queue and the
// output register; o_stall is high during reset and the first cycle after it.

module bresenham_line_rasterizer import brl_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_BITS-1:0]        i_line_color_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_last_pixel
);

    localparam int ENTRY_BITS = 4 * COORD_BITS + 4 + COLOR_BITS;

    logic                  push;
    logic                  pop;
    logic [ENTRY_BITS-1:0] front_entry;
    logic [ENTRY_BITS-1:0] back_entry;
    t_q_status             q_status;

    // classify and set up lines
    brl_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .i_line_color_in (i_line_color_in),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    // decoupling queue
    brl_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_entry),
        .i_pop    (pop),
        .o_data   (back_entry),
        .o_status (q_status)
    );

    // walk lines and emit pixels
    brl_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (back_entry),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

// ----- sv/brl_front.sv -----
// brl_front: accepts input transfers and classifies them; for a start it works out
// absolute deltas, step directions and the major axis. depends on brl_pkg

module brl_front import brl_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_BITS = 4 * COORD_BITS + 4 + COLOR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_BITS-1:0]        i_line_color_in,
    input  t_q_status                    i_q_status,
    output logic                         o_push,
    output logic [ENTRY_BITS-1:0]        o_entry
);

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic                       x_neg;
    logic                       y_neg;
    logic [COORD_BITS:0]        mag_x;
    logic [COORD_BITS:0]        mag_y;
    logic [COORD_BITS-1:0]      delta_x;
    logic [COORD_BITS-1:0]      delta_y;
    logic                       x_major;
    logic                       r_rst_seen;

    // hold off the sender during reset
    always_ff @(posedge i_clk) begin
        r_rst_seen <= i_rst_n;
    end

    // handshake into the queue
    assign o_stall = i_q_status.full || !r_rst_seen;
    assign o_push  = i_valid && !o_stall;

    // signed differences end minus start
    assign diff_x = {i_x_end[COORD_BITS-1], i_x_end} - {i_x_start[COORD_BITS-1], i_x_start};
    assign diff_y = {i_y_end[COORD_BITS-1], i_y_end} - {i_y_start[COORD_BITS-1], i_y_start};
    assign x_neg  = diff_x[COORD_BITS];
    assign y_neg  = diff_y[COORD_BITS];

    // absolute deltas fit in the coordinate width as unsigned
    assign mag_x   = x_neg ? (~diff_x + 1'b1) : diff_x;
    assign mag_y   = y_neg ? (~diff_y + 1'b1) : diff_y;
    assign delta_x = mag_x[COORD_BITS-1:0];
    assign delta_y = mag_y[COORD_BITS-1:0];

    // equal deltas keep x as the major axis
    assign x_major = (delta_x >= delta_y);

    // queue entry layout, unpacked the same way in the back
    assign o_entry = {i_command, x_neg, y_neg, x_major,
                      i_x_start, i_y_start, delta_x, delta_y, i_line_color_in};

endmodule

// ----- sv/brl_queue.sv -----
// brl_queue: short register queue decoupling the front from the back
// depends on brl_pkg for the status struct and depth

module brl_queue import brl_pkg::*; #(
    parameter int WIDTH = 68
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL_COUNT);
    assign o_data         = r_mem[r_rd_ptr];

    // occupancy after this cycle's push and pop
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/brl_back.sv -----
// brl_back: line walker; loads a line on start, emits one pixel per step into
// the output register and advances the decision term. depends on brl_pkg

module brl_back import brl_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_BITS = 4 * COORD_BITS + 4 + COLOR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ENTRY_BITS-1:0]        i_entry,
    input  t_q_status                    i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_last_pixel
);

    localparam int DW = COORD_BITS + 2;
    localparam int LW = COORD_BITS + 1;

    // unpacked queue entry
    logic                  e_cmd;
    logic                  e_x_neg;
    logic                  e_y_neg;
    logic                  e_x_major;
    logic [COORD_BITS-1:0] e_x_start;
    logic [COORD_BITS-1:0] e_y_start;
    logic [COORD_BITS-1:0] e_delta_x;
    logic [COORD_BITS-1:0] e_delta_y;
    logic [COLOR_BITS-1:0] e_color;

    // line state
    logic                  r_active;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [DW-1:0]         r_decision;
    logic [DW-1:0]         r_inc_straight;
    logic [DW-1:0]         r_inc_diag;
    logic                  r_x_neg;
    logic                  r_y_neg;
    logic                  r_x_major;
    logic [LW-1:0]         r_left;
    logic [COLOR_BITS-1:0] r_color;

    // output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    logic                  is_start;
    logic                  emit;
    logic                  out_free;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic [DW-1:0]         init_decision;
    logic [DW-1:0]         init_inc_diag;
    logic                  minor_move;
    logic                  last;
    logic [COORD_BITS-1:0] n_cur_x;
    logic [COORD_BITS-1:0] n_cur_y;
    logic [DW-1:0]         n_decision;

    assign {e_cmd, e_x_neg, e_y_neg, e_x_major,
            e_x_start, e_y_start, e_delta_x, e_delta_y, e_color} = i_entry;

    // pop control: a step on an active line needs room in the output register
    assign is_start = (e_cmd == CMD_START);
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_q_status.empty && (is_start || !r_active || out_free);
    assign emit     = o_pop && !is_start && r_active;

    // line setup from the entry
    assign major         = e_x_major ? e_delta_x : e_delta_y;
    assign minor         = e_x_major ? e_delta_y : e_delta_x;
    assign init_decision = {1'b0, minor, 1'b0} - {2'b00, major};
    assign init_inc_diag = {1'b0, minor, 1'b0} - {1'b0, major, 1'b0};

    // one bresenham step
    assign minor_move = !r_decision[DW-1];
    assign last       = (r_left[LW-1:1] == '0);
    assign n_decision = r_decision + (minor_move ? r_inc_diag : r_inc_straight);
    assign n_cur_x    = (r_x_major || minor_move)
                      ? r_cur_x + (r_x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1)) : r_cur_x;
    assign n_cur_y    = (!r_x_major || minor_move)
                      ? r_cur_y + (r_y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1)) : r_cur_y;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && is_start) begin
                r_active <= 1'b1;
            end else if (emit) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // line datapath
    always_ff @(posedge i_clk) begin
        if (o_pop && is_start) begin
            r_cur_x        <= e_x_start;
            r_cur_y        <= e_y_start;
            r_decision     <= init_decision;
            r_inc_straight <= {1'b0, minor, 1'b0};
            r_inc_diag     <= init_inc_diag;
            r_x_neg        <= e_x_neg;
            r_y_neg        <= e_y_neg;
            r_x_major      <= e_x_major;
            r_left         <= {1'b0, major} + 1'b1;
            r_color        <= e_color;
        end else if (emit) begin
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_decision <= n_decision;
            r_left     <= last ? '0 : r_left - 1'b1;
        end
    end

    // pixel payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_color <= r_color;
            r_out_last  <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

// ----- sv/brl_checker.sv -----
// brl_checker: port-level assertions for the rasterizer, bound to the top level
// depends on brl_pkg for the color width

module brl_checker import brl_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_command,
    input logic signed [COORD_BITS-1:0] i_x_start,
    input logic signed [COORD_BITS-1:0] i_y_start,
    input logic signed [COORD_BITS-1:0] i_x_end,
    input logic signed [COORD_BITS-1:0] i_y_end,
    input logic [COLOR_BITS-1:0]        i_line_color_in,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [COORD_BITS-1:0] o_pixel_x,
    input logic signed [COORD_BITS-1:0] o_pixel_y,
    input logic [COLOR_BITS-1:0]        o_pixel_color,
    input logic                         o_last_pixel
);

    // a stalled pixel stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("pixel dropped while stalled");

    // a stalled pixel keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_pixel_x) && $stable(o_pixel_y)
                               && $stable(o_pixel_color) && $stable(o_last_pixel))
        else $error("stalled pixel payload changed");

    // reset leaves no pixel pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pixel pending after reset");

    // reset blocks input transfers
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input open directly after reset");

    // a pixel needs an item queued after reset is released
    a_no_early_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_rst_n, 1) && $past(i_rst_n, 2))
        else $error("pixel appeared too soon after reset");

endmodule

bind bresenham_line_rasterizer brl_checker #(.COORD_BITS(COORD_BITS)) u_brl_checker (.*);
